// ===== hw/rtl/amph_pkg.sv =====
// shared types, constants and aes helper functions for the hash unit
package amph_pkg;

	localparam int unsigned BlockBytes = 16;
	localparam int unsigned CountWidth = 37;
	localparam int unsigned Rounds = 10;
	localparam logic [7:0] PadByte = 8'h80;
	localparam int unsigned LenBytes = 5;

	typedef enum logic [0:0] {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// ===== hw/rtl/amph_datapath.sv =====
// datapath: chaining value and iterative aes-128 round unit
module amph_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  amph_pkg::dp_cmd_t cmd,
	output amph_pkg::dp_sts_t sts,
	input  logic [127:0]      msg,
	output logic [127:0]      chain
);
	import amph_pkg::*;

	logic [127:0] h_q, s_q, k_q, m_q;
	logic [3:0]   round_q;
	logic         busy_q;
	logic [7:0]   rcon_q;
	logic [127:0] sb, sr, mc, kn, rs;

	// byte i sits at bits [127-8i -: 8]
	always_comb begin
		for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = sbox(s_q[127-8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				sr[127-8*(4*c+i) -: 8] = sb[127-8*(4*((c+i)%4)+i) -: 8];
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sr[127-32*c -: 8];
			a1 = sr[119-32*c -: 8];
			a2 = sr[111-32*c -: 8];
			a3 = sr[103-32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		kn[127:120] = k_q[127:120] ^ sbox(k_q[23:16]) ^ rcon_q;
		kn[119:112] = k_q[119:112] ^ sbox(k_q[15:8]);
		kn[111:104] = k_q[111:104] ^ sbox(k_q[7:0]);
		kn[103:96]  = k_q[103:96] ^ sbox(k_q[31:24]);
		kn[95:64] = k_q[95:64] ^ kn[127:96];
		kn[63:32] = k_q[63:32] ^ kn[95:64];
		kn[31:0]  = k_q[31:0] ^ kn[63:32];
		rs = ((round_q == 4'(Rounds)) ? sr : mc) ^ kn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			busy_q  <= 1'b0;
			round_q <= '0;
			sts     <= '0;
		end else begin
			sts.done <= 1'b0;
			if (cmd.clear) h_q <= '0;
			if (cmd.start) begin
				s_q     <= msg ^ h_q;
				k_q     <= h_q;
				m_q     <= msg;
				rcon_q  <= 8'h01;
				round_q <= 4'd1;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				s_q    <= rs;
				k_q    <= kn;
				rcon_q <= xtime(rcon_q);
				if (round_q == 4'(Rounds)) begin
					busy_q   <= 1'b0;
					h_q      <= h_q ^ rs ^ m_q;
					sts.done <= 1'b1;
				end
				round_q <= round_q + 4'd1;
			end
		end
	end

	assign chain = h_q;
endmodule

// ===== hw/rtl/amph_ctrl.sv =====
// controller: buffers bytes, sequences compressions and padding, drives the result
module amph_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [8:0]        s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [127:0]      m_tdata,
	output amph_pkg::dp_cmd_t cmd,
	input  amph_pkg::dp_sts_t sts,
	output logic [127:0]      msg,
	input  logic [127:0]      chain
);
	import amph_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ABS  = 5'b00010,
		ST_PAD1 = 5'b00100,
		ST_PAD2 = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [127:0] buf_q;
	logic [3:0]   fill_q;
	logic [CountWidth-1:0] cnt_q;
	logic [127:0] padded, lenblk;
	logic [39:0]  bits;
	logic         acc;
	op_t          op;

	assign op  = op_t'(s_tdata[0]);
	assign acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign bits = {cnt_q, 3'b000};
	assign lenblk = {88'd0, bits};

	always_comb begin
		padded = '0;
		for (int i = 0; i < 16; i++)
			if (4'(i) < fill_q) padded[127-8*i -: 8] = buf_q[127-8*i -: 8];
			else if (4'(i) == fill_q) padded[127-8*i -: 8] = PadByte;
		cmd = '0;
		msg = buf_q;
		case (state_q)
			ST_IDLE: if (acc && op == OP_FINISH) begin
				cmd.start = 1'b1;
				msg = (fill_q > 4'(BlockBytes - 1 - LenBytes)) ? padded : (padded | lenblk);
			end
			ST_PAD1: if (sts.done) begin
				cmd.start = 1'b1;
				msg = lenblk;
			end
			ST_OUT: cmd.clear = m_tready;
			default: ;
		endcase
		if (state_q == ST_IDLE && acc && op == OP_ABSORB && fill_q == 4'hf) begin
			cmd.start = 1'b1;
			msg = {buf_q[127:8], s_tdata[8:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					if (op == OP_ABSORB) begin
						cnt_q  <= cnt_q + CountWidth'(1);
						fill_q <= fill_q + 4'd1;
						if (fill_q == 4'hf) state_q <= ST_ABS;
					end else if (fill_q > 4'(BlockBytes - 1 - LenBytes)) begin
						state_q <= ST_PAD1;
					end else begin
						state_q <= ST_PAD2;
					end
				end
				ST_ABS:  if (sts.done) state_q <= ST_IDLE;
				ST_PAD1: if (sts.done) state_q <= ST_PAD2;
				ST_PAD2: if (sts.done) state_q <= ST_OUT;
				ST_OUT: if (m_tready) begin
					state_q <= ST_IDLE;
					fill_q  <= '0;
					cnt_q   <= '0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc && op == OP_ABSORB)
			buf_q[127-8*fill_q -: 8] <= s_tdata[8:1];
	end

	assign m_tdata = {chain[63:0], chain[127:64]};
endmodule

// ===== hw/rtl/aes_miyaguchi_preneel_hash_unit.sv =====
// top level of the aes-128 miyaguchi-preneel hash unit
// channel | dir | tdata fields (low bit up)
// s       | in  | operation[0], data_byte[8:1]
// m       | out | digest_high[63:0], digest_low[127:64]
// absorb: the 16th byte starts a compression in the round unit
// finish: one or two compressions, then the result waits on m_tready
// no item is taken while a compression runs or a result waits
// reset clears the chaining value and counters at once
module aes_miyaguchi_preneel_hash_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // operation, data_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // digest_high, digest_low
);
	import amph_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [127:0] msg, chain;

	amph_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata(s_tdata[8:0]),
		.m_tvalid, .m_tready, .m_tdata, .cmd, .sts, .msg, .chain
	);

	amph_datapath u_dp (.clk, .arst_n, .cmd, .sts, .msg, .chain);
endmodule

// ===== hw/rtl/amph_checker.sv =====
// port-level checker for the hash unit, bound to the top level
module amph_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready)) else $error("input taken while result waits");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid) else $error("result repeated");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready)) else $error("result without compression");
endmodule

bind aes_miyaguchi_preneel_hash_unit amph_checker u_chk (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

// ===== tb/amph_digest_checker.sv =====
// digest predictor and scoreboard watching both channels of the hash unit
`timescale 1ns / 100ps
module amph_digest_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [15:0]  s_tdata,  // operation, data_byte
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,  // digest_high, digest_low
	output int           fail_count,
	output int           pending
);
	import amph_pkg::*;

	logic [7:0]   sb [256];
	logic [127:0] chain;
	logic [7:0]   blk [16];
	int unsigned  fill;
	logic [36:0]  nbytes;
	logic [127:0] digest_q [$];

	function automatic logic [7:0] mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] aes_enc(input logic [127:0] key_in, input logic [127:0] pt);
		logic [7:0] k [16];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] rc;
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			k[i] = key_in[127-8*i -: 8];
			s[i] = pt[127-8*i -: 8] ^ k[i];
		end
		for (int rd = 1; rd <= 10; rd++) begin
			for (int i = 0; i < 16; i++) t[i] = sb[s[i]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) s[4*c+i] = t[4*((c+i)&3)+i];
			if (rd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					s[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
					s[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
					s[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
					s[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
				end
			end
			k[0] = k[0] ^ sb[k[13]] ^ rc;
			k[1] = k[1] ^ sb[k[14]];
			k[2] = k[2] ^ sb[k[15]];
			k[3] = k[3] ^ sb[k[12]];
			for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
			rc = mul2(rc);
			for (int i = 0; i < 16; i++) s[i] = s[i] ^ k[i];
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
		return r;
	endfunction

	function automatic logic [127:0] mp_compress(input logic [127:0] h, input logic [127:0] m);
		return h ^ aes_enc(h, m) ^ m;
	endfunction

	task automatic take_item(input logic [15:0] d);
		logic [127:0] m;
		logic [39:0]  bits;
		m = '0;
		if (op_t'(d[0]) == OP_ABSORB) begin
			blk[fill] = d[8:1];
			fill++;
			nbytes = nbytes + 37'd1;
			if (fill == 16) begin
				for (int i = 0; i < 16; i++) m[127-8*i -: 8] = blk[i];
				chain = mp_compress(chain, m);
				fill = 0;
			end
		end else begin
			for (int i = 0; i < 16; i++) if (i < fill) m[127-8*i -: 8] = blk[i];
			m[127-8*fill -: 8] = PadByte;
			if (15 - fill < LenBytes) begin
				chain = mp_compress(chain, m);
				m = '0;
			end
			bits = {nbytes, 3'b000};
			m[39:0] = bits;
			chain = mp_compress(chain, m);
			digest_q.push_back(chain);
			chain = '0;
			fill = 0;
			nbytes = '0;
		end
	endtask

	initial begin
		for (int i = 0; i < 256; i++) sb[i] = sbox(i[7:0]);
		chain = '0;
		fill = 0;
		nbytes = '0;
		fail_count = 0;
	end

	assign pending = digest_q.size();

	always @(posedge clk) begin
		logic [127:0] e;
		if (arst_n) begin
			if (s_tvalid && s_tready) take_item(s_tdata);
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest %h", m_tdata);
					fail_count++;
				end else begin
					e = digest_q.pop_front();
					if (m_tdata[63:0] !== e[127:64]) begin
						$error("digest_high expected %h actual %h", e[127:64], m_tdata[63:0]);
						fail_count++;
					end
					if (m_tdata[127:64] !== e[63:0]) begin
						$error("digest_low expected %h actual %h", e[63:0], m_tdata[127:64]);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/aes_miyaguchi_preneel_hash_unit_tb.sv =====
// stimulus and verdict for the aes-128 miyaguchi-preneel hash unit
`timescale 1ns / 100ps
module aes_miyaguchi_preneel_hash_unit_tb;
	import amph_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;  // operation, data_byte
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;  // digest_high, digest_low
	int           fail_count;
	int           pending;
	int           cycles;
	bit           calm;

	aes_miyaguchi_preneel_hash_unit u_top (.*);

	amph_digest_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("aes_miyaguchi_preneel_hash_unit_tb failed");
			$finish;
		end
	end

	always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 15);

	task automatic send_item(input op_t op, input logic [7:0] b);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, b, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_message(input int n, input int kind);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: b = 8'h00;
				1: b = 8'hff;
				default: b = 8'($urandom_range(255));
			endcase
			send_item(OP_ABSORB, b);
		end
		send_item(OP_FINISH, 8'($urandom_range(255)));
	endtask

	initial begin
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_message(0, 2);
		send_message(1, 1);
		send_message(10, 0);
		send_message(11, 2);
		send_message(15, 1);
		send_message(16, 2);
		for (int n = 0; n < 1000;) begin
			int len;
			calm = (n > 400 && n < 550);
			if ($urandom_range(9) == 0) len = 16 + $urandom_range(40);
			else len = $urandom_range(20);
			send_message(len, 2 + $urandom_range(3) / 3);
			n += len + 1;
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("aes_miyaguchi_preneel_hash_unit_tb passed");
		else
			$display("aes_miyaguchi_preneel_hash_unit_tb failed");
		$finish;
	end

endmodule
